>>> rtl/core/pteq_pkg.sv
package pteq_pkg;

    localparam int CAPACITY_DEF  = 16;
    localparam int MAX_FIRES_DEF = 16;
    localparam int RESULT_ROOM   = 16;

    typedef enum logic [2:0] {
        FUNC_TICK       = 3'd0,
        FUNC_SCHEDULE   = 3'd1,
        FUNC_CHECK      = 3'd2,
        FUNC_REMOVE     = 3'd3,
        FUNC_REMOVE_ALL = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        KIND_ACK    = 2'd0,
        KIND_FIRED  = 2'd1,
        KIND_REJECT = 2'd2
    } kind_t;

    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] event_id;
        logic [31:0] due_time;
        logic [31:0] repeat_interval;
        logic [31:0] current_time;
    } req_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [31:0] fired_or_queried_id;
        logic        found;
        logic        last;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic load_req;    // capture request
        logic scan_start;  // clear best, start at slot 0
        logic scan_step;   // compare one slot
        logic by_id;       // restrict scan to request id
        logic do_fire;     // fire / re-arm best slot
        logic do_insert;   // insert into free slot
        logic do_remove;   // invalidate best slot
        logic do_clear;    // clear all valid bits
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic        scan_done;
        logic        best_ok;     // a best slot exists
        logic        best_due;    // best slot due at or before current time
        logic        free_ok;
        logic [31:0] best_id;     // id held in the best slot
    } sts_t;

endpackage

>>> rtl/core/periodic_timed_event_queue_top.sv
// Timed event queue: a table of CAPACITY events (id, due time, repeat interval)
// served one request at a time; a new request is taken only once the previous
// one has sent its last result. Schedule, remove-all and unknown codes answer
// from the decode state; check, remove and a tick that fires nothing take a
// linear scan of the table. A tick fires with a look-ahead scan: each fired
// result is held until the following scan shows whether another event is due.
// A result stays on the output while the receiver stalls it.
module periodic_timed_event_queue_top
    import pteq_pkg::*;
#(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int MAX_FIRES = MAX_FIRES_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  req_t in_data,
    output logic out_valid,
    input  logic out_stall,
    output rsp_t out_data
);
    cmd_t cmd;
    sts_t sts;
    req_t req_q;

    pteq_datapath #(.CAPACITY(CAPACITY)) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (in_data),
        .cmd   (cmd),
        .sts   (sts),
        .req_q (req_q)
    );

    pteq_ctrl #(.MAX_FIRES(MAX_FIRES)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .req_q     (req_q),
        .sts       (sts),
        .cmd       (cmd)
    );

endmodule

>>> rtl/core/pteq_datapath.sv
module pteq_datapath
    import pteq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  req_t  req,
    input  cmd_t  cmd,
    output sts_t  sts,
    output req_t  req_q
);
    localparam int SW = $clog2(CAPACITY);

    logic [CAPACITY-1:0] valid_reg;
    logic [31:0]         id_mem  [CAPACITY];
    logic [31:0]         due_mem [CAPACITY];
    logic [31:0]         ivl_mem [CAPACITY];
    logic [15:0]         ord_mem [CAPACITY];
    logic [15:0]         counter_reg;

    req_t        req_reg;
    logic [SW:0] idx_reg;
    logic        best_ok_reg;
    logic [SW-1:0] best_reg;
    logic [31:0] best_due_reg;
    logic [15:0] best_age_reg;
    logic [31:0] best_ivl_reg;
    logic [31:0] best_id_reg;

    logic [SW-1:0] cur;
    logic [15:0]   cur_age;
    logic          cand;
    logic          better;
    logic [32:0]   sum;
    logic [SW-1:0] free_slot;
    logic          free_ok;

    assign cur     = idx_reg[SW-1:0];
    assign cur_age = counter_reg - ord_mem[cur];
    assign cand    = valid_reg[cur] && (!cmd.by_id || id_mem[cur] == req_reg.event_id);
    // scan runs upward so equal age keeps the lower slot
    assign better  = !best_ok_reg || due_mem[cur] < best_due_reg
                     || (due_mem[cur] == best_due_reg && cur_age > best_age_reg);
    assign sum     = {1'b0, best_due_reg} + {1'b0, best_ivl_reg};

    always_comb
    begin
        free_slot = '0;
        free_ok   = 1'b0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_slot = SW'(i);
                free_ok   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            counter_reg <= '0;
            idx_reg     <= '0;
            best_ok_reg <= 1'b0;
        end
        else
        begin
            if (cmd.scan_start)
            begin
                idx_reg     <= '0;
                best_ok_reg <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                idx_reg <= idx_reg + 1'b1;
                if (cand && better)
                begin
                    best_ok_reg <= 1'b1;
                end
            end
            if (cmd.do_fire)
            begin
                if (best_ivl_reg != '0)
                begin
                    counter_reg <= counter_reg + 16'd1;
                end
                else
                begin
                    valid_reg[best_reg] <= 1'b0;
                end
            end
            if (cmd.do_insert)
            begin
                valid_reg[free_slot] <= 1'b1;
                counter_reg          <= counter_reg + 16'd1;
            end
            if (cmd.do_remove)
            begin
                valid_reg[best_reg] <= 1'b0;
            end
            if (cmd.do_clear)
            begin
                valid_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg <= req;
        end
        if (cmd.scan_step && cand && better)
        begin
            best_reg     <= cur;
            best_due_reg <= due_mem[cur];
            best_age_reg <= cur_age;
            best_ivl_reg <= ivl_mem[cur];
            best_id_reg  <= id_mem[cur];
        end
        if (cmd.do_fire && best_ivl_reg != '0)
        begin
            due_mem[best_reg] <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            ord_mem[best_reg] <= counter_reg;
        end
        if (cmd.do_insert)
        begin
            id_mem[free_slot]  <= req_reg.event_id;
            due_mem[free_slot] <= req_reg.due_time;
            ivl_mem[free_slot] <= req_reg.repeat_interval;
            ord_mem[free_slot] <= counter_reg;
        end
    end

    assign sts.scan_done = idx_reg == (SW+1)'(CAPACITY);
    assign sts.best_ok   = best_ok_reg;
    assign sts.best_due  = best_due_reg <= req_reg.current_time;
    assign sts.free_ok   = free_ok;
    assign sts.best_id   = best_id_reg;
    assign req_q         = req_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_insert |-> free_ok)
        else $error("insert with table full");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_clear |=> valid_reg == '0)
        else $error("clear left valid entries");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.do_fire || cmd.do_remove) |-> best_ok_reg)
        else $error("update without a selected slot");

endmodule

>>> rtl/core/pteq_ctrl.sv
module pteq_ctrl
    import pteq_pkg::*;
#(
    parameter int MAX_FIRES = MAX_FIRES_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    output logic out_valid,
    input  logic out_stall,
    output rsp_t out_data,
    input  req_t req_q,
    input  sts_t sts,
    output cmd_t cmd
);
    localparam int LIMIT = MAX_FIRES < RESULT_ROOM ? MAX_FIRES : RESULT_ROOM;
    localparam int FW    = $clog2(LIMIT + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_SCAN, S_ACT, S_OUT
    } state_t;

    state_t          state_reg;
    logic [FW-1:0]   fires_reg;
    logic            out_valid_reg;
    rsp_t            out_reg;
    logic            more_reg;  // after this result, scan again
    logic            pend_reg;  // a fired id waits for the next scan
    logic [31:0]     pend_id_reg;

    logic by_id;
    assign by_id = req_q.func != FUNC_TICK;

    always_comb
    begin
        cmd            = '0;
        cmd.by_id      = by_id;
        cmd.load_req   = state_reg == S_IDLE && in_valid;
        cmd.scan_start = state_reg == S_DECODE;
        cmd.scan_step  = state_reg == S_SCAN && !sts.scan_done;
        if (state_reg == S_DECODE)
        begin
            cmd.do_insert = req_q.func == FUNC_SCHEDULE && req_q.event_id != '0
                            && sts.free_ok;
            cmd.do_clear  = req_q.func == FUNC_REMOVE_ALL;
        end
        if (state_reg == S_ACT)
        begin
            cmd.do_fire   = req_q.func == FUNC_TICK && sts.best_ok && sts.best_due
                            && fires_reg != FW'(LIMIT);
            cmd.do_remove = req_q.func == FUNC_REMOVE && req_q.event_id != '0
                            && sts.best_ok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fires_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            more_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            pend_id_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_DECODE;
                        fires_reg <= '0;
                        pend_reg  <= 1'b0;
                    end
                end
                S_DECODE:
                begin
                    unique case (req_q.func)
                        FUNC_TICK, FUNC_CHECK, FUNC_REMOVE:
                        begin
                            state_reg <= S_SCAN;
                        end
                        FUNC_SCHEDULE:
                        begin
                            out_reg.result_kind <= (req_q.event_id != '0 && sts.free_ok)
                                                   ? KIND_ACK : KIND_REJECT;
                            out_reg.fired_or_queried_id <= req_q.event_id;
                            out_reg.found <= 1'b0;
                            out_reg.last  <= 1'b1;
                            more_reg      <= 1'b0;
                            out_valid_reg <= 1'b1;
                            state_reg     <= S_OUT;
                        end
                        FUNC_REMOVE_ALL:
                        begin
                            out_reg       <= '{KIND_ACK, 32'd0, 1'b0, 1'b1};
                            more_reg      <= 1'b0;
                            out_valid_reg <= 1'b1;
                            state_reg     <= S_OUT;
                        end
                        default:
                        begin
                            out_reg.result_kind <= KIND_REJECT;
                            out_reg.fired_or_queried_id <= req_q.event_id;
                            out_reg.found <= 1'b0;
                            out_reg.last  <= 1'b1;
                            more_reg      <= 1'b0;
                            out_valid_reg <= 1'b1;
                            state_reg     <= S_OUT;
                        end
                    endcase
                end
                S_SCAN:
                begin
                    if (sts.scan_done)
                    begin
                        state_reg <= S_ACT;
                    end
                end
                S_ACT:
                begin
                    if (req_q.func != FUNC_TICK)
                    begin
                        out_reg.result_kind <= KIND_ACK;
                        out_reg.fired_or_queried_id <= req_q.event_id;
                        out_reg.found <= req_q.event_id != '0 && sts.best_ok;
                        out_reg.last  <= 1'b1;
                        more_reg      <= 1'b0;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_OUT;
                    end
                    else if (pend_reg)
                    begin
                        // held fire is final unless this scan fires another
                        out_reg.result_kind <= KIND_FIRED;
                        out_reg.fired_or_queried_id <= pend_id_reg;
                        out_reg.found <= 1'b0;
                        out_reg.last  <= !cmd.do_fire;
                        more_reg      <= cmd.do_fire;
                        pend_reg      <= cmd.do_fire;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_OUT;
                        if (cmd.do_fire)
                        begin
                            pend_id_reg <= sts.best_id;
                            fires_reg   <= fires_reg + 1'b1;
                        end
                    end
                    else if (cmd.do_fire)
                    begin
                        pend_reg    <= 1'b1;
                        pend_id_reg <= sts.best_id;
                        fires_reg   <= fires_reg + 1'b1;
                        state_reg   <= S_DECODE;
                    end
                    else
                    begin
                        out_reg       <= '{KIND_ACK, 32'd0, 1'b0, 1'b1};
                        more_reg      <= 1'b0;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= more_reg ? S_DECODE : S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> state_reg == S_OUT)
        else $error("result shown outside output state");
    assert property (@(posedge clk) disable iff (!rst_n)
        fires_reg <= FW'(LIMIT))
        else $error("fire count beyond limit");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !out_valid)
        else $error("result pending in idle");

endmodule
